FILE: rtl/ndcag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndcag_pkg
// Shared constants for the n-dimensional crop address generator: register
// map, axis setup field positions and stream payload widths.
// ----------------------------------------------------------------------------
package ndcag_pkg;

  // apb register map, one 64-bit register every 8 bytes
  localparam int unsigned APB_DATA_W    = 64;
  localparam int unsigned APB_ADDR_W    = 6;
  localparam int unsigned REG_IDX_LSB   = 3;
  localparam int unsigned REG_IDX_W     = APB_ADDR_W - REG_IDX_LSB;

  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_BASE  = 3'd1;
  localparam int unsigned          SETUP_REGS     = 4;

  // num_dims register
  localparam int unsigned NUM_DIMS_W = 3;

  // axis setup register fields
  localparam int unsigned EXTENT_LSB = 0;
  localparam int unsigned START_LSB  = 16;
  localparam int unsigned STRIDE_LSB = 32;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned STRIDE_W   = 32;
  localparam int unsigned SETUP_W    = 64;

  // stream payloads
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 2 * INDEX_W;

endpackage

FILE: rtl/nd_crop_address_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_crop_address_generator_unit
// Odometer-style address generator for an n-dimensional crop: each request
// transfer yields one (input index, output index) pair and a last flag.
// ----------------------------------------------------------------------------
// Usage: one request transfer is taken every cycle and produces exactly one
// result transfer via the position/count, per-axis multiplier and index sum
// registers. The per-axis position counters and the element counter are
// updated as the request is taken, so back to back requests run at one per
// cycle; the rate is limited only by the result side backpressure, which
// stalls the whole three-stage pipe. Setup registers must be written over apb
// only while no transfer is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module nd_crop_address_generator_unit #(
  parameter int unsigned MAX_AXES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ndcag_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ndcag_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ndcag_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ndcag_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ndcag_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // [31:0] input_index,
                                                              // [63:32] output_index
  output logic                                m_axis_tlast    // last
);
  import ndcag_pkg::*;

  localparam int unsigned NUM_SETUP = (MAX_AXES < SETUP_REGS) ? MAX_AXES : SETUP_REGS;
  localparam int unsigned NW        = $clog2(MAX_AXES + 1);
  localparam int unsigned SUM_W     = POS_W + 1;
  localparam int unsigned MUL_W     = SUM_W + STRIDE_W;

  // configuration registers
  logic [NUM_DIMS_W-1:0] num_dims_q;
  logic [SETUP_W-1:0]    setup_q [NUM_SETUP];

  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  reg_idx;

  // per-axis views of the setup registers
  logic [POS_W-1:0]      ext   [MAX_AXES];
  logic [POS_W-1:0]      start [MAX_AXES];
  logic [STRIDE_W-1:0]   stride[MAX_AXES];
  logic [NW-1:0]         n_act;

  // odometer state
  logic [POS_W-1:0]      pos_q   [MAX_AXES];
  logic [POS_W-1:0]      pos_eff [MAX_AXES];
  logic [POS_W-1:0]      pos_nx  [MAX_AXES];
  logic [INDEX_W-1:0]    cnt_q;
  logic [INDEX_W-1:0]    cnt_eff;
  logic                  last_c;
  logic                  carry;

  // pipeline
  logic                  pipe_en;
  logic                  s_xfer;
  logic                  v0_q, v1_q, v2_q;
  logic [POS_W-1:0]      pos0_q  [MAX_AXES];
  logic [INDEX_W-1:0]    cnt0_q, cnt1_q, oidx_q;
  logic                  last0_q, last1_q, olast_q;
  logic [MUL_W-1:0]      mul_w   [MAX_AXES];
  logic [INDEX_W-1:0]    prod1_q [MAX_AXES];
  logic [INDEX_W-1:0]    isum_c;
  logic [INDEX_W-1:0]    iidx_q;

  // apb access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NUM_DIMS_W'(1);
      for (int i = 0; i < NUM_SETUP; i++) setup_q[i] <= '0;
    end else if (cfg_wr) begin
      if (reg_idx == REG_NUM_DIMS) num_dims_q <= pwdata[NUM_DIMS_W-1:0];
      for (int i = 0; i < NUM_SETUP; i++) begin
        if (reg_idx == REG_AXIS_BASE + REG_IDX_W'(i)) setup_q[i] <= pwdata;
      end
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_NUM_DIMS) prdata = APB_DATA_W'(num_dims_q);
    for (int i = 0; i < NUM_SETUP; i++) begin
      if (reg_idx == REG_AXIS_BASE + REG_IDX_W'(i)) prdata = setup_q[i];
    end
  end

  // axis fields, axes without a register read as zero
  for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
    if (a < NUM_SETUP) begin : g_reg
      assign ext[a]    = setup_q[a][EXTENT_LSB +: POS_W];
      assign start[a]  = setup_q[a][START_LSB  +: POS_W];
      assign stride[a] = setup_q[a][STRIDE_LSB +: STRIDE_W];
    end else begin : g_zero
      assign ext[a]    = '0;
      assign start[a]  = '0;
      assign stride[a] = '0;
    end
  end

  // clamp the axis count to 1..MAX_AXES
  always_comb begin
    priority if (num_dims_q == '0) begin
      n_act = NW'(1);
    end else if (32'(num_dims_q) > MAX_AXES) begin
      n_act = NW'(MAX_AXES);
    end else begin
      n_act = NW'(num_dims_q);
    end
  end

  // handshake: the whole pipe advances unless a result is held
  assign pipe_en       = !v2_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // restart clears positions and count before this element
  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) pos_eff[a] = s_axis_tdata[0] ? '0 : pos_q[a];
    cnt_eff = s_axis_tdata[0] ? '0 : cnt_q;
  end

  // last flag and odometer advance, innermost active axis first
  always_comb begin
    last_c = 1'b1;
    carry  = 1'b1;
    for (int a = 0; a < MAX_AXES; a++) pos_nx[a] = pos_eff[a];
    for (int a = 0; a < MAX_AXES; a++) begin
      if (NW'(a) < n_act && ({1'b0, pos_eff[a]} + SUM_W'(1) < {1'b0, ext[a]})) last_c = 1'b0;
    end
    for (int d = MAX_AXES - 1; d >= 0; d--) begin
      if (NW'(d) < n_act && carry) begin
        if ({1'b0, pos_eff[d]} + SUM_W'(1) < {1'b0, ext[d]}) begin
          pos_nx[d] = pos_eff[d] + POS_W'(1);
          carry     = 1'b0;
        end else begin
          pos_nx[d] = '0;
        end
      end
    end
  end

  // odometer and element counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < MAX_AXES; a++) pos_q[a] <= '0;
      cnt_q <= '0;
    end else if (s_xfer) begin
      for (int a = 0; a < MAX_AXES; a++) pos_q[a] <= pos_nx[a];
      cnt_q <= last_c ? '0 : cnt_eff + INDEX_W'(1);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q <= s_xfer;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // per-axis (position + start) * stride, modulo 2^32
  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      mul_w[a] = MUL_W'({1'b0, pos0_q[a]} + {1'b0, start[a]}) * MUL_W'(stride[a]);
    end
  end

  // index sum over the axis products
  always_comb begin
    isum_c = '0;
    for (int a = 0; a < MAX_AXES; a++) isum_c = isum_c + prod1_q[a];
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int a = 0; a < MAX_AXES; a++) pos0_q[a] <= pos_eff[a];
      cnt0_q  <= cnt_eff;
      last0_q <= last_c;
      for (int a = 0; a < MAX_AXES; a++) begin
        prod1_q[a] <= (NW'(a) < n_act) ? mul_w[a][INDEX_W-1:0] : '0;
      end
      cnt1_q  <= cnt0_q;
      last1_q <= last0_q;
      iidx_q  <= isum_c;
      oidx_q  <= cnt1_q;
      olast_q <= last1_q;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {oidx_q, iidx_q};
  assign m_axis_tlast  = olast_q;

  // counter returns to zero after the final element of a pass
  a_cnt_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && last_c |=> cnt_q == '0)
    else $error("element count did not wrap after last element");

  // counter steps by one inside a pass
  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !last_c |=> cnt_q == $past(cnt_eff) + INDEX_W'(1))
    else $error("element count did not advance by one");

  // no request taken while a result is held back
  a_no_take_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !m_axis_tready |-> !s_xfer)
    else $error("request taken while result stalled");

  // held result keeps its contents
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !m_axis_tready |=> v2_q && $stable(iidx_q) && $stable(oidx_q) && $stable(olast_q))
    else $error("stalled result changed");

endmodule
